// File: design/fccsw_pkg.sv
// Shared types and constants of the FAT16 cluster chain sector walker.
`default_nettype none
package fccsw_pkg;

  localparam int TABLE_ENTRIES_DEF = 2048;
  localparam int MAX_SECTORS_DEF   = 64;
  localparam int SECTOR_BYTES      = 512;

  localparam logic [15:0] END_OF_CHAIN       = 16'hFFF8;
  localparam logic [15:0] RESERVED_LOW       = 16'hFFF0;
  localparam logic [15:0] FIRST_DATA_CLUSTER = 16'd2;
  localparam logic [7:0]  SPC_MAX            = 8'd128;
  localparam logic [9:0]  SECTOR_TAKE        = 10'd512;

  // Configuration register indexes.
  localparam int          CFG_IDX_W      = 1;
  localparam logic [0:0]  CFG_DATA_START = 1'b0;
  localparam logic [0:0]  CFG_SPC        = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_END = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr;     // store one table entry
    logic start;  // load a read request
    logic check;  // classify the cluster and form its first sector
    logic emit;   // load one result into the output register
    logic fetch;  // take the next cluster from the table
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic in_read;     // request at the input is a read
    logic count_zero;  // its byte count is zero
    logic err;         // current cluster ends the walk with an error
    logic last;        // this sector completes the byte count
    logic sic_end;     // this is the final sector of the cluster
  } sts_t;

endpackage
`default_nettype wire

// File: design/fccsw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module fccsw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: design/fccsw_ctrl.sv
// Controller state machine of the sector walker.
`default_nettype none
module fccsw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire fccsw_pkg::sts_t sts_i,
  output fccsw_pkg::cmd_t    cmd_o
);
  import fccsw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_EMIT  = 4'b0100,
    S_FETCH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.wr    = accept && !sts_i.in_read;
    cmd_o.start = accept && sts_i.in_read && !sts_i.count_zero;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.start) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.err || sts_i.last) begin
            state_d = S_IDLE;
          end else if (sts_i.sic_end) begin
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_CHECK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A table read is only waited for after the final sector of a cluster went out.
  a_fetch_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |-> ($past(cmd_o.emit) && $past(sts_i.sic_end)))
    else $error("table fetch without a finished cluster");

  a_check_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (($past(state_q) == S_IDLE) || ($past(state_q) == S_FETCH)))
    else $error("cluster check entered from a wrong state");

  a_err_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && sts_i.err) |=> (state_q == S_IDLE))
    else $error("walk continued after an error result");

endmodule
`default_nettype wire

// File: design/fccsw_dpath.sv
// Datapath of the sector walker: configuration, table, walk registers and result register.
`default_nettype none
module fccsw_dpath #(
  parameter int TABLE_ENTRIES           = fccsw_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_SECTORS_PER_REQUEST = fccsw_pkg::MAX_SECTORS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [fccsw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i,
  input  wire logic                            in_kind_i,
  input  wire logic [15:0]                     in_cluster_index_i,
  input  wire logic [15:0]                     in_entry_value_i,
  input  wire logic [15:0]                     in_byte_count_i,
  input  wire fccsw_pkg::cmd_t                 cmd_i,
  output fccsw_pkg::sts_t                      sts_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [31:0]                          out_sector_number_o,
  output logic [14:0]                          out_buffer_offset_o,
  output logic [9:0]                           out_bytes_in_sector_o,
  output logic [1:0]                           out_status_o,
  output logic                                 out_last_o
);
  import fccsw_pkg::*;

  localparam int          AW        = $clog2(TABLE_ENTRIES);
  localparam logic [16:0] TableEnd  = 17'(TABLE_ENTRIES);
  localparam logic [15:0] ByteLimit = 16'(MAX_SECTORS_PER_REQUEST * SECTOR_BYTES);

  logic [31:0] data_start_q;
  logic [7:0]  cfg_spc_q;
  logic [7:0]  spc_q;
  logic [15:0] count_q;
  logic [15:0] cluster_q;
  logic [6:0]  sic_q;
  logic [15:0] done_q;
  logic [31:0] base_q;
  logic [1:0]  err_q;

  logic [15:0] remaining;
  logic [9:0]  take;
  logic [23:0] cluster_prod;
  logic [1:0]  err_d;
  logic [15:0] rdata;
  logic        tbl_we;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q <= '0;
      cfg_spc_q    <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DATA_START: data_start_q <= cfg_data_i;
        CFG_SPC:        cfg_spc_q    <= cfg_data_i[7:0];
        default:        data_start_q <= data_start_q;
      endcase
    end
  end

  assign tbl_we = cmd_i.wr && ({1'b0, in_cluster_index_i} < TableEnd);

  fccsw_ram #(
    .WIDTH(16),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(in_cluster_index_i[AW-1:0]),
    .wdata_i(in_entry_value_i),
    .re_i   (cmd_i.emit),
    .raddr_i(cluster_q[AW-1:0]),
    .rdata_o(rdata)
  );

  assign remaining    = count_q - done_q;
  assign take         = (remaining <= 16'(SECTOR_BYTES)) ? remaining[9:0] : SECTOR_TAKE;
  assign cluster_prod = (cluster_q - FIRST_DATA_CLUSTER) * spc_q;

  always_comb begin
    if (cluster_q >= END_OF_CHAIN) begin
      err_d = ST_END;
    end else if ((cluster_q < FIRST_DATA_CLUSTER) || ({1'b0, cluster_q} >= TableEnd) ||
                 (cluster_q >= RESERVED_LOW)) begin
      err_d = ST_BAD;
    end else begin
      err_d = ST_OK;
    end
  end

  assign sts_o.out_free   = !out_valid_o || out_ready_i;
  assign sts_o.in_read    = in_kind_i;
  assign sts_o.count_zero = (in_byte_count_i == '0);
  assign sts_o.err        = (err_q != ST_OK);
  assign sts_o.last       = (remaining <= 16'(SECTOR_BYTES));
  assign sts_o.sic_end    = ({1'b0, sic_q} == (spc_q - 8'd1));

  // Walk registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_q <= '0;
      sic_q     <= '0;
      done_q    <= '0;
      count_q   <= '0;
      spc_q     <= 8'd1;
      err_q     <= ST_OK;
      base_q    <= '0;
    end else begin
      if (cmd_i.start) begin
        cluster_q <= in_cluster_index_i;
        sic_q     <= '0;
        done_q    <= '0;
        count_q   <= (in_byte_count_i > ByteLimit) ? ByteLimit : in_byte_count_i;
        if (cfg_spc_q == '0) begin
          spc_q <= 8'd1;
        end else if (cfg_spc_q > SPC_MAX) begin
          spc_q <= SPC_MAX;
        end else begin
          spc_q <= cfg_spc_q;
        end
      end
      if (cmd_i.check) begin
        err_q  <= err_d;
        base_q <= data_start_q + 32'(cluster_prod);
      end
      if (cmd_i.emit && (err_q == ST_OK)) begin
        done_q <= done_q + 16'(take);
        sic_q  <= sic_q + 7'd1;
      end
      if (cmd_i.fetch) begin
        cluster_q <= rdata;
        sic_q     <= '0;
      end
    end
  end

  // Result register; it can be refilled in the cycle its current result is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_buffer_offset_o <= done_q[14:0];
      if (err_q != ST_OK) begin
        out_sector_number_o   <= '0;
        out_bytes_in_sector_o <= '0;
        out_status_o          <= err_q;
        out_last_o            <= 1'b1;
      end else begin
        out_sector_number_o   <= base_q + 32'(sic_q);
        out_bytes_in_sector_o <= take;
        out_status_o          <= ST_OK;
        out_last_o            <= sts_o.last;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/fat16_cluster_chain_sector_walker_top.sv
// Top level of the FAT16 cluster chain sector walker.
// A table write gives no result. A read with a nonzero byte count is loaded into the
// walk registers, then the check state forms its first sector number; results go out
// one sector per cycle inside a cluster while the output is not stalled, and each step
// along the chain adds a fetch state for the table read and a check state for the multiply.
// Reset clears the walk and the data start and sets sectors per cluster to one; the table holds nothing until written.
`default_nettype none
module fat16_cluster_chain_sector_walker_top #(
  parameter int TABLE_ENTRIES           = fccsw_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_SECTORS_PER_REQUEST = fccsw_pkg::MAX_SECTORS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [fccsw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // cluster_index [15:0], entry_value [31:16], byte_count [47:32]
  input  wire logic [47:0]                     s_axis_tdata,
  // kind [0]
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // sector_number [31:0], buffer_offset [46:32], bytes_in_sector [56:47], zeros [63:57]
  output logic [63:0]                          m_axis_tdata,
  // status [1:0]
  output logic [1:0]                           m_axis_tuser,
  output logic                                 m_axis_tlast
);
  import fccsw_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] sector_number;
  logic [14:0] buffer_offset;
  logic [9:0]  bytes_in_sector;

  fccsw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  fccsw_dpath #(
    .TABLE_ENTRIES          (TABLE_ENTRIES),
    .MAX_SECTORS_PER_REQUEST(MAX_SECTORS_PER_REQUEST)
  ) u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_kind_i            (s_axis_tuser),
    .in_cluster_index_i   (s_axis_tdata[15:0]),
    .in_entry_value_i     (s_axis_tdata[31:16]),
    .in_byte_count_i      (s_axis_tdata[47:32]),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .out_valid_o          (m_axis_tvalid),
    .out_ready_i          (m_axis_tready),
    .out_sector_number_o  (sector_number),
    .out_buffer_offset_o  (buffer_offset),
    .out_bytes_in_sector_o(bytes_in_sector),
    .out_status_o         (m_axis_tuser),
    .out_last_o           (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, bytes_in_sector, buffer_offset, sector_number};

endmodule
`default_nettype wire
